>>> rtl/kdacc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdacc_pkg
// Shared types and constants for the key-switching digit accumulator.
// ----------------------------------------------------------------------------

package kdacc_pkg;

  localparam int unsigned WORD_BITS_DEF  = 32;
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 32;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MODULUS      = 2'd0,
    REG_BARRETT_MU   = 2'd1,
    REG_MODULUS_BITS = 2'd2
  } cfg_reg_t;

  // Operations of the shared modular unit
  typedef enum logic {
    OP_SCAN,  // acc = (2*acc + bit*operand) mod q over every bit of word, MSB first
    OP_ADD    // acc = (word + operand) mod q in one step
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_SB,
    S_RED_SA,
    S_RED_D,
    S_MUL_B,
    S_ADD_B,
    S_MUL_A,
    S_ADD_A,
    S_RED_C,
    S_ADD_C,
    S_EMIT
  } seq_state_t;

endpackage

>>> rtl/kdacc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdacc_ifs
// Valid/ready channels for digit beats in and coefficient results out.
// ----------------------------------------------------------------------------

interface kdacc_in_if #(
  parameter int unsigned WORD_BITS = kdacc_pkg::WORD_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] digit_value;
  logic [WORD_BITS-1:0] key_b_word;
  logic [WORD_BITS-1:0] key_a_word;
  logic [WORD_BITS-1:0] b_coefficient;
  logic                 last_digit;

  modport source (
    output valid, digit_value, key_b_word, key_a_word, b_coefficient, last_digit,
    input  ready
  );
  modport sink (
    input  valid, digit_value, key_b_word, key_a_word, b_coefficient, last_digit,
    output ready
  );
endinterface

interface kdacc_out_if #(
  parameter int unsigned WORD_BITS = kdacc_pkg::WORD_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] new_b;
  logic [WORD_BITS-1:0] new_a;

  modport source (
    output valid, new_b, new_a,
    input  ready
  );
  modport sink (
    input  valid, new_b, new_a,
    output ready
  );
endinterface

>>> rtl/key_switch_digit_accumulate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_switch_digit_accumulate
// Per-coefficient key-switching digit accumulator for one CRT tower.
// ----------------------------------------------------------------------------
// Each beat carries one digit with its two key words; the block forms digit*key
// modulo q for both key parts, exactly and fully reduced, and adds them into two
// running sums. On the beat marked last it adds the b coefficient to the first
// sum, offers (new_b, new_a) on the result channel and clears both sums. All
// arithmetic runs on one shared modular add/double unit that works one bit per
// cycle, so a new beat is taken only once the last one is through, and after
// a last digit only once its result has gone into the result register. After
// a modulus write the next beat first reduces the kept sums by the new q. A
// modulus of zero means 2^WORD_BITS. The Barrett constant and bit-length
// registers are accepted but not stored: reduction here is exact without them.
// ----------------------------------------------------------------------------

module key_switch_digit_accumulate #(
  parameter int unsigned WORD_BITS = kdacc_pkg::WORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write_en,
  input  logic [kdacc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [kdacc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  kdacc_in_if.sink                             item,
  kdacc_out_if.source                          result
);
  import kdacc_pkg::*;

  logic [WORD_BITS-1:0] modulus;
  logic [WORD_BITS:0]   q;
  logic                 mod_write;

  logic                 res_valid;
  logic                 res_ready;
  logic [WORD_BITS-1:0] res_new_b;
  logic [WORD_BITS-1:0] res_new_a;

  logic                 out_valid;
  logic [WORD_BITS-1:0] out_new_b;
  logic [WORD_BITS-1:0] out_new_a;

  always_comb begin
    mod_write = 1'b0;
    if (cfg_write_en) begin
      unique case (cfg_index)
        REG_MODULUS: begin
          mod_write = 1'b1;
        end
        // Drop: the reduction is exact and needs neither value
        REG_BARRETT_MU, REG_MODULUS_BITS: begin
          mod_write = 1'b0;
        end
        default: begin
          mod_write = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WORD_BITS'(2);
    end else if (mod_write) begin
      modulus <= cfg_data[WORD_BITS-1:0];
    end
  end

  assign q = (modulus == '0) ? {1'b1, {WORD_BITS{1'b0}}} : {1'b0, modulus};

  kdacc_seq #(
    .WORD_BITS (WORD_BITS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .q             (q),
    .mod_write     (mod_write),
    .in_valid      (item.valid),
    .in_ready      (item.ready),
    .digit_value   (item.digit_value),
    .key_b_word    (item.key_b_word),
    .key_a_word    (item.key_a_word),
    .b_coefficient (item.b_coefficient),
    .last_digit    (item.last_digit),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_new_b     (res_new_b),
    .res_new_a     (res_new_a)
  );

  // Output register: take a new result when empty or being drained this cycle
  assign res_ready = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_new_b <= res_new_b;
      out_new_a <= res_new_a;
    end
  end

  assign result.valid = out_valid;
  assign result.new_b = out_new_b;
  assign result.new_a = out_new_a;

endmodule

>>> rtl/kdacc_modunit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdacc_modunit
// Shared modular add/double unit: interleaved shift-and-add multiply or
// reduction, one bit per cycle, plus a single-step modular add.
// ----------------------------------------------------------------------------

module kdacc_modunit #(
  parameter int unsigned WORD_BITS = kdacc_pkg::WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  kdacc_pkg::unit_ctl_t  ctl,
  input  logic [WORD_BITS:0]    q,
  input  logic [WORD_BITS-1:0]  word,
  input  logic [WORD_BITS-1:0]  operand,
  output kdacc_pkg::unit_sts_t  sts,
  output logic [WORD_BITS-1:0]  result
);
  import kdacc_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] scan;
  logic [CNT_BITS-1:0]  cnt;
  logic                 busy;
  logic                 done;

  logic [WORD_BITS+1:0] base;
  logic [WORD_BITS+1:0] addend;
  logic [WORD_BITS+1:0] total;
  logic [WORD_BITS+1:0] q1;
  logic [WORD_BITS+1:0] q2;
  logic [WORD_BITS+1:0] red;
  logic                 add_bit;

  // The doubled acc stays below 2q and the operand below q, so the sum is below 3q: at most two subtractions
  always_comb begin
    base    = busy ? {1'b0, acc, 1'b0} : {2'b00, word};
    add_bit = busy ? scan[WORD_BITS-1] : 1'b1;
    addend  = add_bit ? {2'b00, operand} : '0;
    total   = base + addend;
    q1      = {1'b0, q};
    q2      = {q, 1'b0};
    priority if (total >= q2) begin
      red = total - q2;
    end else if (total >= q1) begin
      red = total - q1;
    end else begin
      red = total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (ctl.start) begin
        if (ctl.op == OP_SCAN) begin
          busy <= 1'b1;
          cnt  <= CNT_BITS'(WORD_BITS);
        end else begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      acc  <= red[WORD_BITS-1:0];
      scan <= {scan[WORD_BITS-2:0], 1'b0};
    end else if (ctl.start) begin
      if (ctl.op == OP_SCAN) begin
        acc  <= '0;
        scan <= word;
      end else begin
        acc <= red[WORD_BITS-1:0];
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign result   = acc;

`ifndef NO_ASSERTIONS
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("modunit: done raised while still stepping");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst) ctl.start |-> !busy)
    else $error("modunit: start issued while busy");
  a_cnt_live: assert property (@(posedge clk) disable iff (rst) busy |-> cnt != '0)
    else $error("modunit: busy with empty step count");
  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, acc} < q))
    else $error("modunit: result not below modulus");
`endif

endmodule

>>> rtl/kdacc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdacc_seq
// Sequencer: holds the digit beat and the two running sums and steps the
// shared modular unit through reduce, multiply and add phases.
// ----------------------------------------------------------------------------

module kdacc_seq #(
  parameter int unsigned WORD_BITS = kdacc_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [WORD_BITS:0]   q,
  input  logic                 mod_write,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [WORD_BITS-1:0] digit_value,
  input  logic [WORD_BITS-1:0] key_b_word,
  input  logic [WORD_BITS-1:0] key_a_word,
  input  logic [WORD_BITS-1:0] b_coefficient,
  input  logic                 last_digit,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [WORD_BITS-1:0] res_new_b,
  output logic [WORD_BITS-1:0] res_new_a
);
  import kdacc_pkg::*;

  seq_state_t state, state_next;

  logic [WORD_BITS-1:0] digit;
  logic [WORD_BITS-1:0] key_b;
  logic [WORD_BITS-1:0] key_a;
  logic [WORD_BITS-1:0] b_coef;
  logic                 last;
  logic [WORD_BITS-1:0] dr;
  logic [WORD_BITS-1:0] sum_b;
  logic [WORD_BITS-1:0] sum_a;
  logic                 pending;
  logic                 fresh;

  unit_ctl_t            ctl;
  unit_sts_t            sts;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] operand;
  logic [WORD_BITS-1:0] unit_res;
  logic [WORD_BITS-1:0] one_q;

  // 1 mod q, which is zero for a modulus of one
  assign one_q = (q == (WORD_BITS+1)'(1)) ? '0 : WORD_BITS'(1);

  kdacc_modunit #(
    .WORD_BITS (WORD_BITS)
  ) u_modunit (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .q       (q),
    .word    (word),
    .operand (operand),
    .sts     (sts),
    .result  (unit_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl.start  = 1'b0;
    ctl.op     = OP_SCAN;
    word       = '0;
    operand    = one_q;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = fresh ? S_RED_D : S_RED_SB;
        end
      end
      // Sums left over from an earlier modulus: bring them below the new q
      S_RED_SB: begin
        ctl.start = !pending;
        word      = sum_b;
        if (sts.done) begin
          state_next = S_RED_SA;
        end
      end
      S_RED_SA: begin
        ctl.start = !pending;
        word      = sum_a;
        if (sts.done) begin
          state_next = S_RED_D;
        end
      end
      S_RED_D: begin
        ctl.start = !pending;
        word      = digit;
        if (sts.done) begin
          state_next = S_MUL_B;
        end
      end
      S_MUL_B: begin
        ctl.start = !pending;
        word      = key_b;
        operand   = dr;
        if (sts.done) begin
          state_next = S_ADD_B;
        end
      end
      S_ADD_B: begin
        ctl.start = !pending;
        ctl.op    = OP_ADD;
        word      = unit_res;
        operand   = sum_b;
        if (sts.done) begin
          state_next = S_MUL_A;
        end
      end
      S_MUL_A: begin
        ctl.start = !pending;
        word      = key_a;
        operand   = dr;
        if (sts.done) begin
          state_next = S_ADD_A;
        end
      end
      S_ADD_A: begin
        ctl.start = !pending;
        ctl.op    = OP_ADD;
        word      = unit_res;
        operand   = sum_a;
        if (sts.done) begin
          state_next = last ? S_RED_C : S_IDLE;
        end
      end
      S_RED_C: begin
        ctl.start = !pending;
        word      = b_coef;
        if (sts.done) begin
          state_next = S_ADD_C;
        end
      end
      S_ADD_C: begin
        ctl.start = !pending;
        ctl.op    = OP_ADD;
        word      = unit_res;
        operand   = sum_b;
        if (sts.done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      fresh   <= 1'b1;
      sum_b   <= '0;
      sum_a   <= '0;
    end else begin
      if (sts.done) begin
        pending <= 1'b0;
      end else if (ctl.start) begin
        pending <= 1'b1;
      end

      if (mod_write) begin
        fresh <= 1'b0;
      end else if (state == S_RED_SA && sts.done) begin
        fresh <= 1'b1;
      end

      if (sts.done && (state == S_RED_SB || state == S_ADD_B || state == S_ADD_C)) begin
        sum_b <= unit_res;
      end
      if (sts.done && (state == S_RED_SA || state == S_ADD_A)) begin
        sum_a <= unit_res;
      end
      // Result taken: start the next coefficient from zero
      if (state == S_EMIT && res_ready) begin
        sum_b <= '0;
        sum_a <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      digit  <= digit_value;
      key_b  <= key_b_word;
      key_a  <= key_a_word;
      b_coef <= b_coefficient;
      last   <= last_digit;
    end
    if (state == S_RED_D && sts.done) begin
      dr <= unit_res;
    end
  end

  assign res_new_b = sum_b;
  assign res_new_a = sum_a;

`ifndef NO_ASSERTIONS
  a_sums_reduced: assert property (@(posedge clk) disable iff (rst)
    fresh |-> (({1'b0, sum_b} < q) && ({1'b0, sum_a} < q)))
    else $error("seq: running sum not below modulus");
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pending)
    else $error("seq: unit operation outstanding in idle");
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_RED_D || state == S_RED_SB))
    else $error("seq: accepted beat did not start work");
`endif

endmodule
